### rtl/core/gmh_pkg.sv
// ----------------------------------------------------------------------------
// gmh_pkg
// Shared codes, widths and stage records of the grid minimum-height
// normalizer.
// ----------------------------------------------------------------------------
package gmh_pkg;

    localparam int COORD_W      = 16;
    localparam int HEIGHT_W     = 17;
    localparam int ORIGIN_W     = 13;
    localparam int OP_W         = 2;
    localparam int STATUS_W     = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 40;
    localparam int WORD_W       = COORD_W + 1;

    localparam logic [OP_W-1:0] OP_ACCUM = 2'd0;
    localparam logic [OP_W-1:0] OP_NORM  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_MIN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 2'd1;

    localparam logic signed [ORIGIN_W-1:0] ORIGIN_RESET = -13'sd128;

    typedef struct packed {
        logic                valid;
        logic [OP_W-1:0]     op;
        logic [COORD_W-1:0]  z;
        logic                in_range;
    } gmh_item_t;

    typedef struct packed {
        logic                valid;
        logic [HEIGHT_W-1:0] height;
        logic [COORD_W-1:0]  cell_floor;
        logic [STATUS_W-1:0] status;
    } gmh_result_t;

    typedef struct packed {
        logic busy;
        logic start;
    } gmh_sweep_t;

endpackage

### rtl/core/grid_min_height_normalizer.sv
// ----------------------------------------------------------------------------
// grid_min_height_normalizer
// Points with x, y and z in millimetres are placed in a GRID_SIDE square grid
// of CELL_MM cells. Accumulate keeps each cell's lowest z, normalize returns z
// minus that minimum, and clear erases all cell marks. One point is taken per
// clock cycle while the output is not stalled and no sweep or clear is pending,
// with one read-modify-write of the cell memory per point. After reset, and
// after each clear, s_tready stays low while a sweep walks the cell memory one
// entry per cycle over all GRID_SIDE * GRID_SIDE entries (65536 at the default
// size); a clear also waits for the points ahead of it to finish.
// ----------------------------------------------------------------------------
module grid_min_height_normalizer #(
    parameter int GRID_SIDE = 256,
    parameter int CELL_MM   = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gmh_pkg::IN_TDATA_W-1:0]    s_tdata,  // x_mm, y_mm, z_mm
    input  logic [gmh_pkg::OP_W-1:0]          s_tuser,  // operation
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [gmh_pkg::OUT_TDATA_W-1:0]   m_tdata,  // height_above_min, cell_floor
    output logic [gmh_pkg::STATUS_W-1:0]      m_tuser,  // status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gmh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gmh_pkg::ORIGIN_W-1:0]      cfg_data
);
    import gmh_pkg::*;

    localparam int AW = $clog2(GRID_SIDE * GRID_SIDE);

    logic [ORIGIN_W-1:0] origin_x_reg, origin_y_reg;
    logic                clear_pend_reg, clear_pend_next;
    logic                m_valid_reg;
    logic [HEIGHT_W-1:0] m_height_reg;
    logic [COORD_W-1:0]  m_floor_reg;
    logic [STATUS_W-1:0] m_status_reg;

    logic        adv;
    logic        accept;
    gmh_item_t   item;
    logic [AW-1:0] addr;
    gmh_result_t result;
    gmh_sweep_t  sweep;

    assign adv       = !m_valid_reg || m_tready;
    assign s_tready  = adv && !sweep.busy && !clear_pend_reg;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - HEIGHT_W - COORD_W)'(0), m_floor_reg, m_height_reg};
    assign m_tuser  = m_status_reg;

    always_comb
    begin
        clear_pend_next = clear_pend_reg;
        if (accept && (s_tuser == OP_CLEAR))
        begin
            clear_pend_next = 1'b1;
        end
        else if (sweep.start)
        begin
            clear_pend_next = 1'b0;
        end
    end

    gmh_cell_map #(
        .GRID_SIDE (GRID_SIDE),
        .CELL_MM   (CELL_MM),
        .AW        (AW)
    ) u_cell_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (accept),
        .in_op    (s_tuser),
        .in_x     (s_tdata[COORD_W-1:0]),
        .in_y     (s_tdata[2*COORD_W-1:COORD_W]),
        .in_z     (s_tdata[3*COORD_W-1:2*COORD_W]),
        .origin_x (origin_x_reg),
        .origin_y (origin_y_reg),
        .item     (item),
        .addr     (addr)
    );

    gmh_cell_store #(
        .GRID_SIDE (GRID_SIDE),
        .AW        (AW)
    ) u_cell_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .item   (item),
        .addr   (addr),
        .result (result),
        .sweep  (sweep)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg   <= ORIGIN_RESET;
            origin_y_reg   <= ORIGIN_RESET;
            clear_pend_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            clear_pend_reg <= clear_pend_next;
            if (adv)
            begin
                m_valid_reg <= result.valid;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ORIGIN_X: origin_x_reg <= cfg_data;
                    REG_ORIGIN_Y: origin_y_reg <= cfg_data;
                    default:      origin_x_reg <= origin_x_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m_height_reg <= result.height;
            m_floor_reg  <= result.cell_floor;
            m_status_reg <= result.status;
        end
    end

endmodule

### rtl/core/gmh_cell_map.sv
// ----------------------------------------------------------------------------
// gmh_cell_map
// Four-stage pipeline that rounds x and y to cell coordinates, subtracts the
// grid origin and forms the grid address and the in-range flag.
// ----------------------------------------------------------------------------
module gmh_cell_map #(
    parameter int GRID_SIDE = 256,
    parameter int CELL_MM   = 10,
    parameter int AW        = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [gmh_pkg::OP_W-1:0]      in_op,
    input  logic [gmh_pkg::COORD_W-1:0]   in_x,
    input  logic [gmh_pkg::COORD_W-1:0]   in_y,
    input  logic [gmh_pkg::COORD_W-1:0]   in_z,
    input  logic [gmh_pkg::ORIGIN_W-1:0]  origin_x,
    input  logic [gmh_pkg::ORIGIN_W-1:0]  origin_y,
    output gmh_pkg::gmh_item_t            item,
    output logic [AW-1:0]                 addr
);
    import gmh_pkg::*;

    localparam int D     = 2 * CELL_MM;
    localparam int M_MAX = 65536 + CELL_MM;
    localparam int MW    = $clog2(M_MAX + 1);
    localparam int SHIFT = MW;
    localparam int RECIP = (2 ** SHIFT) / D;
    localparam int RW    = $clog2(RECIP + 1);
    localparam int PW    = MW + RW;
    localparam int QMAX  = M_MAX / D;
    localparam int QW    = $clog2(QMAX + 1);
    localparam int DW    = $clog2(D + 1);
    localparam int CW    = QW + 1;
    localparam int LW    = ((CW > ORIGIN_W) ? CW : ORIGIN_W) + 1;
    localparam int SW    = $clog2(GRID_SIDE);

    // Stage 1: magnitude terms 2|v| + CELL_MM.
    logic               s1_valid_reg;
    logic [OP_W-1:0]    s1_op_reg;
    logic [COORD_W-1:0] s1_z_reg;
    logic               s1_sx_reg, s1_sy_reg;
    logic [MW-1:0]      s1_mx_reg, s1_my_reg;

    // Stage 2: reciprocal estimate of the quotient.
    logic               s2_valid_reg;
    logic [OP_W-1:0]    s2_op_reg;
    logic [COORD_W-1:0] s2_z_reg;
    logic               s2_sx_reg, s2_sy_reg;
    logic [MW-1:0]      s2_mx_reg, s2_my_reg;
    logic [QW-1:0]      s2_qx_reg, s2_qy_reg;

    // Stage 3: corrected quotient.
    logic               s3_valid_reg;
    logic [OP_W-1:0]    s3_op_reg;
    logic [COORD_W-1:0] s3_z_reg;
    logic               s3_sx_reg, s3_sy_reg;
    logic [QW-1:0]      s3_qx_reg, s3_qy_reg;

    // Stage 4: column and row relative to the origin.
    logic                 s4_valid_reg;
    logic [OP_W-1:0]      s4_op_reg;
    logic [COORD_W-1:0]   s4_z_reg;
    logic signed [LW-1:0] s4_col_reg, s4_row_reg;

    logic [COORD_W:0]     abs_x, abs_y, ext_x, ext_y;
    logic [MW-1:0]        mx_next, my_next;
    logic [PW-1:0]        prod_x, prod_y;
    logic [QW+DW-1:0]     qd_x, qd_y;
    logic [MW-1:0]        rem_x, rem_y;
    logic [QW-1:0]        qx_next, qy_next;
    logic signed [LW-1:0] cx, cy, col_next, row_next;
    logic                 in_range;

    always_comb
    begin
        ext_x   = {in_x[COORD_W-1], in_x};
        ext_y   = {in_y[COORD_W-1], in_y};
        abs_x   = in_x[COORD_W-1] ? (COORD_W+1)'(-ext_x) : ext_x;
        abs_y   = in_y[COORD_W-1] ? (COORD_W+1)'(-ext_y) : ext_y;
        mx_next = MW'({abs_x, 1'b0}) + MW'(CELL_MM);
        my_next = MW'({abs_y, 1'b0}) + MW'(CELL_MM);
    end

    assign prod_x = PW'(s1_mx_reg) * PW'(RECIP);
    assign prod_y = PW'(s1_my_reg) * PW'(RECIP);

    always_comb
    begin
        qd_x    = (QW+DW)'(s2_qx_reg) * (QW+DW)'(D);
        qd_y    = (QW+DW)'(s2_qy_reg) * (QW+DW)'(D);
        rem_x   = s2_mx_reg - MW'(qd_x);
        rem_y   = s2_my_reg - MW'(qd_y);
        qx_next = s2_qx_reg + QW'(rem_x >= MW'(D));
        qy_next = s2_qy_reg + QW'(rem_y >= MW'(D));
    end

    always_comb
    begin
        cx       = s3_sx_reg ? -LW'({1'b0, s3_qx_reg}) : LW'({1'b0, s3_qx_reg});
        cy       = s3_sy_reg ? -LW'({1'b0, s3_qy_reg}) : LW'({1'b0, s3_qy_reg});
        col_next = cx - LW'($signed(origin_x));
        row_next = cy - LW'($signed(origin_y));
    end

    always_comb
    begin
        in_range = !s4_col_reg[LW-1] && (s4_col_reg[LW-2:0] < (LW-1)'(GRID_SIDE))
                && !s4_row_reg[LW-1] && (s4_row_reg[LW-2:0] < (LW-1)'(GRID_SIDE));
        addr     = '0;
        if (in_range)
        begin
            addr = AW'(AW'(s4_row_reg[SW-1:0]) * AW'(GRID_SIDE)) + AW'(s4_col_reg[SW-1:0]);
        end
        item.valid    = s4_valid_reg;
        item.op       = s4_op_reg;
        item.z        = s4_z_reg;
        item.in_range = in_range;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg  <= in_op;
            s1_z_reg   <= in_z;
            s1_sx_reg  <= in_x[COORD_W-1];
            s1_sy_reg  <= in_y[COORD_W-1];
            s1_mx_reg  <= mx_next;
            s1_my_reg  <= my_next;

            s2_op_reg  <= s1_op_reg;
            s2_z_reg   <= s1_z_reg;
            s2_sx_reg  <= s1_sx_reg;
            s2_sy_reg  <= s1_sy_reg;
            s2_mx_reg  <= s1_mx_reg;
            s2_my_reg  <= s1_my_reg;
            s2_qx_reg  <= prod_x[SHIFT +: QW];
            s2_qy_reg  <= prod_y[SHIFT +: QW];

            s3_op_reg  <= s2_op_reg;
            s3_z_reg   <= s2_z_reg;
            s3_sx_reg  <= s2_sx_reg;
            s3_sy_reg  <= s2_sy_reg;
            s3_qx_reg  <= qx_next;
            s3_qy_reg  <= qy_next;

            s4_op_reg  <= s3_op_reg;
            s4_z_reg   <= s3_z_reg;
            s4_col_reg <= col_next;
            s4_row_reg <= row_next;
        end
    end

endmodule

### rtl/core/gmh_cell_store.sv
// ----------------------------------------------------------------------------
// gmh_cell_store
// Cell memory holding a valid mark and the minimum height of every cell.
// Performs the read-modify-write of each point and the clearing sweep.
// ----------------------------------------------------------------------------
module gmh_cell_store #(
    parameter int GRID_SIDE = 256,
    parameter int AW        = $clog2(GRID_SIDE * GRID_SIDE)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  gmh_pkg::gmh_item_t   item,
    input  logic [AW-1:0]        addr,
    output gmh_pkg::gmh_result_t result,
    output gmh_pkg::gmh_sweep_t  sweep
);
    import gmh_pkg::*;

    localparam int CELLS = GRID_SIDE * GRID_SIDE;

    logic [WORD_W-1:0] mem [CELLS];

    gmh_item_t         item_reg;
    logic [AW-1:0]     addr_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              busy_reg, busy_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              last_we_reg;
    logic [AW-1:0]     last_addr_reg;
    logic [WORD_W-1:0] last_wdata_reg;

    logic [WORD_W-1:0] word;
    logic              cell_valid;
    logic [COORD_W-1:0] cell_min, new_min;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [WORD_W-1:0] wdata;
    logic              start;

    always_comb
    begin
        word       = (last_we_reg && (last_addr_reg == addr_reg)) ? last_wdata_reg : rd_data_reg;
        cell_valid = word[WORD_W-1];
        cell_min   = word[COORD_W-1:0];
        new_min    = (!cell_valid || ($signed(item_reg.z) < $signed(cell_min)))
                   ? item_reg.z : cell_min;
    end

    always_comb
    begin
        result.valid      = item_reg.valid;
        result.height     = {item_reg.z[COORD_W-1], item_reg.z};
        result.cell_floor = '0;
        result.status     = STAT_OK;
        case (item_reg.op)
            OP_ACCUM:
            begin
                if (!item_reg.in_range)
                begin
                    result.status = STAT_OUTSIDE;
                end
                else
                begin
                    result.cell_floor = new_min;
                end
            end
            OP_NORM:
            begin
                if (!item_reg.in_range)
                begin
                    result.status = STAT_OUTSIDE;
                end
                else if (cell_valid)
                begin
                    result.cell_floor = cell_min;
                    result.height     = {item_reg.z[COORD_W-1], item_reg.z}
                                      - {cell_min[COORD_W-1], cell_min};
                end
                else
                begin
                    result.status = STAT_NO_MIN;
                end
            end
            default:
            begin
                result.status = STAT_OK;
            end
        endcase
    end

    always_comb
    begin
        start = adv && item_reg.valid && (item_reg.op == OP_CLEAR);
        we    = busy_reg
             || (adv && item_reg.valid && item_reg.in_range && (item_reg.op == OP_ACCUM));
        waddr = busy_reg ? ptr_reg : addr_reg;
        wdata = busy_reg ? '0 : {1'b1, new_min};

        busy_next = busy_reg;
        ptr_next  = ptr_reg;
        if (busy_reg)
        begin
            if (ptr_reg == AW'(CELLS - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            ptr_next  = '0;
        end

        sweep.busy  = busy_reg;
        sweep.start = start;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (adv)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            addr_reg <= addr;
        end
        if (adv || busy_reg)
        begin
            last_addr_reg  <= waddr;
            last_wdata_reg <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg    <= '0;
            busy_reg    <= 1'b1;
            ptr_reg     <= '0;
            last_we_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            ptr_reg  <= ptr_next;
            if (adv)
            begin
                item_reg <= item;
            end
            if (adv || busy_reg)
            begin
                last_we_reg <= we;
            end
        end
    end

endmodule
